@@ rtl/core/wpm_pkg.sv @@
`timescale 1ns / 1ps

package wpm_pkg;

    // Pattern store depth and derived widths
    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SYM_W       = 8;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_TEXT   = 2'd3
    } t_cmd;

    // Request from the front end to the row engine
    typedef struct packed {
        logic              clear_row;
        logic              go;
        logic              is_text;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
    } t_row_cmd;

    // Row engine status back to the front end
    typedef struct packed {
        logic busy;
        logic res_valid;
        logic matched;
    } t_row_stat;

endpackage

@@ rtl/core/wpm_pattern_store.sv @@
`timescale 1ns / 1ps

module wpm_pattern_store
    import wpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [SYM_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [SYM_W-1:0]  o_rd_data
);

    logic [SYM_W-1:0] r_mem [MAX_PATTERN];
    logic [SYM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/wpm_row_engine.sv @@
`timescale 1ns / 1ps

module wpm_row_engine
    import wpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_row_cmd          i_cmd,
    input  logic              i_take,
    input  logic [SYM_W-1:0]  i_pat_sym,
    output logic [ADDR_W-1:0] o_rd_addr,
    output t_row_stat         o_stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    t_state             r_state;
    logic [MAX_PATTERN:0] r_row;      // rotates one column per step
    logic [LEN_W-1:0]   r_col;
    logic               r_is_text;
    logic [SYM_W-1:0]   r_sym;
    logic               r_prev;       // new value of the column to the left
    logic               r_diag;       // old value of the column to the left
    logic               r_matched;
    logic               n_bit;
    logic               w_above;

    assign w_above = r_row[0];

    // One dynamic-programming cell, shared by every column
    always_comb begin
        n_bit = 1'b0;
        if (r_col == '0) begin
            n_bit = !r_is_text;
        end else if (r_col <= i_cmd.len) begin
            if (!r_is_text) begin
                n_bit = r_prev && (i_pat_sym == SYM_STAR);
            end else if (r_sym == i_pat_sym || i_pat_sym == SYM_ANY) begin
                n_bit = r_diag;
            end else if (i_pat_sym == SYM_STAR) begin
                n_bit = w_above | r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_matched <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.clear_row) begin
                        r_row <= '0;
                    end
                    if (i_cmd.go) begin
                        r_col     <= '0;
                        r_is_text <= i_cmd.is_text;
                        r_sym     <= i_cmd.sym;
                        r_state   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_row  <= {n_bit, r_row[MAX_PATTERN:1]};
                    r_prev <= n_bit;
                    r_diag <= w_above;
                    if (r_col == i_cmd.len) begin
                        r_matched <= n_bit;
                    end
                    if (r_col == LEN_W'(MAX_PATTERN)) begin
                        r_state <= ST_HOLD;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (i_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Address column j's symbol so it arrives for column j+1
    assign o_rd_addr        = r_col[ADDR_W-1:0];
    assign o_stat.busy      = (r_state != ST_IDLE);
    assign o_stat.res_valid = (r_state == ST_HOLD);
    assign o_stat.matched   = r_matched;

endmodule

@@ rtl/core/wildcard_pattern_matcher_top.sv @@
`timescale 1ns / 1ps

// Wildcard pattern matcher. Load a pattern with clear (command 0) and append
// (command 1) transfers; '?' matches any one byte and '*' any run of bytes.
// Symbols past MAX_PATTERN (64) are dropped and o_pattern_overflow is raised
// until the next clear. Command 2 starts a text and command 3 feeds one text
// byte; each of these returns one result transfer telling whether the text
// since the last start matches the whole pattern. Clear and append return
// nothing. Start and text items sweep the dynamic-programming row through a
// single shared cell, one pattern column per cycle over all MAX_PATTERN + 1
// columns, so each holds o_stall high through the column steps and the handoff
// to the output register, and longer while the output register still holds an
// earlier result that is stalled downstream. The rate is set by that single
// cell and the one read port of the pattern store. A finished result sits in
// the output register, so the next item can be taken while the previous result
// is still stalled downstream.

module wildcard_pattern_matcher_top
    import wpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_command,
    input  logic [SYM_W-1:0] i_symbol,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_matched,
    output logic             o_pattern_overflow
);

    logic [LEN_W-1:0]  r_len;
    logic              r_ovf;
    logic              r_out_valid;
    logic              r_out_matched;
    logic              r_out_ovf;

    logic              w_accept;
    logic              w_take;
    logic              w_we;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [SYM_W-1:0]  w_pat_sym;
    t_row_cmd          w_cmd;
    t_row_stat         w_stat;
    t_cmd              w_op;

    assign w_op     = t_cmd'(i_command);
    assign w_accept = i_valid && !o_stall;

    // Hold off new items while the row sweep runs or its result waits to be taken
    assign o_stall = w_stat.busy;

    // Append only while there is room in the store
    assign w_we = w_accept && (w_op == CMD_APPEND) && (r_len < LEN_W'(MAX_PATTERN));

    always_comb begin
        w_cmd           = '0;
        w_cmd.sym       = i_symbol;
        w_cmd.len       = r_len;
        w_cmd.is_text   = (w_op == CMD_TEXT);
        if (w_accept) begin
            case (w_op)
                CMD_CLEAR, CMD_APPEND: w_cmd.clear_row = 1'b1;
                CMD_START, CMD_TEXT:   w_cmd.go        = 1'b1;
                default:               w_cmd.go        = 1'b0;
            endcase
        end
    end

    // Move a finished result into the output register once it is free
    assign w_take = w_stat.res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && w_op == CMD_CLEAR) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (w_accept && w_op == CMD_APPEND) begin
                if (w_we) begin
                    r_len <= r_len + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_matched <= w_stat.matched;
            r_out_ovf     <= r_ovf;
        end
    end

    wpm_pattern_store u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data (i_symbol),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_pat_sym)
    );

    wpm_row_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_take    (w_take),
        .i_pat_sym (w_pat_sym),
        .o_rd_addr (w_rd_addr),
        .o_stat    (w_stat)
    );

    assign o_valid            = r_out_valid;
    assign o_matched          = r_out_matched;
    assign o_pattern_overflow = r_out_ovf;

    // Overflow can only be flagged with a full store
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LEN_W'(MAX_PATTERN)))
        else $error("overflow flagged with room left in pattern store");

    // A new result only appears after the engine offered one
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_stat.res_valid))
        else $error("result transfer without a finished row sweep");

    // Pattern length never moves while a sweep is in flight
    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy && $past(w_stat.busy) |-> $stable(r_len))
        else $error("pattern length changed during row sweep");

endmodule
